### src/assert_macros.svh
// assertion macros for the top-level rtl file, which checks its own logic
// no dependencies; pulled in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TUF_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tuf assertion failed");

// next-cycle implication, disabled during reset
`define TUF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tuf assertion failed");

`endif

### src/tuf_pkg.sv
// shared types and constants of the timestamped union-find unit
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package tuf_pkg;

   localparam int NODES   = 4096;
   localparam int IDX_W   = 12;
   localparam int TIME_W  = 12;
   localparam int SIZE_W  = 13;
   localparam int ADDR_W  = $clog2(NODES);

   localparam logic [TIME_W-1:0] TIME_MAX  = '1;
   localparam logic [IDX_W:0]    NODES_LIM = (IDX_W+1)'(NODES);

   localparam logic MODE_MERGE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;

   typedef struct packed {
      logic             mode;
      logic [IDX_W-1:0] node_a;
      logic [IDX_W-1:0] node_b;
   } tuf_req_type;

   typedef struct packed {
      logic              found;
      logic [TIME_W-1:0] earliest_time;
   } tuf_rsp_type;

   // one node: parent link, merge stamp (zero at a root), size of the set it roots
   typedef struct packed {
      logic [ADDR_W-1:0] parent;
      logic [TIME_W-1:0] stamp;
      logic [SIZE_W-1:0] set_size;
   } tuf_entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      tuf_entry_type     wr_data;
   } tuf_ram_req_type;

   typedef struct packed {
      logic clearing;
      logic busy;
   } tuf_status_type;

endpackage

### src/tuf_node_ram.sv
// node memory: parent link, stamp and set size for every node
// one write port, one registered read port; depends on tuf_pkg
`timescale 1ns / 1ps

module tuf_node_ram (
   input  logic                     clock,
   input  tuf_pkg::tuf_ram_req_type ram_req,
   output tuf_pkg::tuf_entry_type   rd_data
);

   tuf_pkg::tuf_entry_type mem [tuf_pkg::NODES];
   tuf_pkg::tuf_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tuf_seq.sv
// sequencer of the union-find unit: clearing pass, root walks, merge writes,
// binary search over merge times and the result register; depends on tuf_pkg
`timescale 1ns / 1ps

module tuf_seq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  tuf_pkg::tuf_req_type     req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output tuf_pkg::tuf_rsp_type     rsp_data,
   output tuf_pkg::tuf_ram_req_type ram_req,
   input  tuf_pkg::tuf_entry_type   rd_data,
   output tuf_pkg::tuf_status_type  status
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_DISPATCH = 4'd2;
   localparam logic [3:0] S_WSTART   = 4'd3;
   localparam logic [3:0] S_WCHK     = 4'd4;
   localparam logic [3:0] S_AFTER    = 4'd5;
   localparam logic [3:0] S_LINK     = 4'd6;
   localparam logic [3:0] S_SIZE     = 4'd7;
   localparam logic [3:0] S_PROBE    = 4'd8;
   localparam logic [3:0] S_RESP     = 4'd9;

   localparam int AW = tuf_pkg::ADDR_W;
   localparam int TW = tuf_pkg::TIME_W;
   localparam int SW = tuf_pkg::SIZE_W;
   localparam logic [AW-1:0] LAST_NODE = AW'(tuf_pkg::NODES - 1);

   logic [3:0]          state_ff, state_in;
   logic [AW-1:0]       clr_idx_ff, clr_idx_in;
   tuf_pkg::tuf_req_type item_ff, item_in;
   logic                sel_ff, sel_in;
   logic [AW-1:0]       cur_ff, cur_in;
   logic [TW-1:0]       probe_ff, probe_in;
   logic [AW-1:0]       root_a_ff, root_a_in, root_b_ff, root_b_in;
   logic [SW-1:0]       size_a_ff, size_a_in, size_b_ff, size_b_in;
   logic [TW:0]         lo_ff, lo_in, hi_ff, hi_in;
   logic [TW-1:0]       mc_ff, mc_in;
   logic                a_big_ff, a_big_in;
   tuf_pkg::tuf_rsp_type res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   tuf_pkg::tuf_rsp_type rsp_data_ff, rsp_data_in;

   logic          in_range;
   logic          follow;
   logic [TW+1:0] lo_hi_sum;
   logic [TW:0]   mc_next;

   // shared compare: a link is taken when stamped and not later than the probe time
   assign follow    = (rd_data.stamp != '0) && (rd_data.stamp <= probe_ff);
   assign in_range  = ({1'b0, item_ff.node_a} < tuf_pkg::NODES_LIM) &&
                      ({1'b0, item_ff.node_b} < tuf_pkg::NODES_LIM);
   assign lo_hi_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
   assign mc_next   = {1'b0, mc_ff} + (TW+1)'(1);

   always_comb begin
      state_in     = state_ff;
      clr_idx_in   = clr_idx_ff;
      item_in      = item_ff;
      sel_in       = sel_ff;
      cur_in       = cur_ff;
      probe_in     = probe_ff;
      root_a_in    = root_a_ff;
      root_b_in    = root_b_ff;
      size_a_in    = size_a_ff;
      size_b_in    = size_b_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mc_in        = mc_ff;
      a_big_in     = a_big_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      ram_req      = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_req.wr_en                = 1'b1;
            ram_req.wr_addr              = clr_idx_ff;
            ram_req.wr_data.parent       = clr_idx_ff;
            ram_req.wr_data.stamp        = '0;
            ram_req.wr_data.set_size     = SW'(1);
            clr_idx_in                   = clr_idx_ff + AW'(1);
            if (clr_idx_ff == LAST_NODE) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (item_ff.mode == tuf_pkg::MODE_MERGE) begin
               if (!in_range || mc_ff == tuf_pkg::TIME_MAX) begin
                  state_in = S_IDLE;
               end else begin
                  probe_in = tuf_pkg::TIME_MAX;
                  sel_in   = 1'b0;
                  state_in = S_WSTART;
               end
            end else if (!in_range) begin
               res_in   = '0;
               state_in = S_RESP;
            end else begin
               lo_in    = '0;
               hi_in    = mc_next;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            if (lo_ff < hi_ff) begin
               probe_in = lo_hi_sum[TW:1];
               sel_in   = 1'b0;
               state_in = S_WSTART;
            end else begin
               res_in.found         = (lo_ff != mc_next);
               res_in.earliest_time = (lo_ff != mc_next) ? lo_ff[TW-1:0] : '0;
               state_in             = S_RESP;
            end
         end
         S_WSTART: begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = sel_ff ? item_ff.node_b[AW-1:0] : item_ff.node_a[AW-1:0];
            cur_in          = ram_req.rd_addr;
            state_in        = S_WCHK;
         end
         S_WCHK: begin
            // one link per cycle: the parent read is issued straight from the returned entry
            if (follow) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = rd_data.parent;
               cur_in          = rd_data.parent;
            end else if (!sel_ff) begin
               root_a_in = cur_ff;
               size_a_in = rd_data.set_size;
               sel_in    = 1'b1;
               state_in  = S_WSTART;
            end else begin
               root_b_in = cur_ff;
               size_b_in = rd_data.set_size;
               state_in  = S_AFTER;
            end
         end
         S_AFTER: begin
            if (item_ff.mode == tuf_pkg::MODE_MERGE) begin
               if (root_a_ff == root_b_ff) begin
                  state_in = S_IDLE;
               end else begin
                  mc_in    = mc_next[TW-1:0];
                  a_big_in = (size_a_ff > size_b_ff);
                  state_in = S_LINK;
               end
            end else begin
               if (root_a_ff == root_b_ff) begin
                  hi_in = {1'b0, probe_ff};
               end else begin
                  lo_in = {1'b0, probe_ff} + (TW+1)'(1);
               end
               state_in = S_PROBE;
            end
         end
         S_LINK: begin
            // smaller root goes under the larger, ties put a's root under b's
            ram_req.wr_en            = 1'b1;
            ram_req.wr_addr          = a_big_ff ? root_b_ff : root_a_ff;
            ram_req.wr_data.parent   = a_big_ff ? root_a_ff : root_b_ff;
            ram_req.wr_data.stamp    = mc_ff;
            ram_req.wr_data.set_size = a_big_ff ? size_b_ff : size_a_ff;
            state_in                 = S_SIZE;
         end
         S_SIZE: begin
            ram_req.wr_en            = 1'b1;
            ram_req.wr_addr          = a_big_ff ? root_a_ff : root_b_ff;
            ram_req.wr_data.parent   = a_big_ff ? root_a_ff : root_b_ff;
            ram_req.wr_data.stamp    = '0;
            ram_req.wr_data.set_size = size_a_ff + size_b_ff;
            state_in                 = S_IDLE;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_idx_ff   <= '0;
         mc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         mc_ff        <= mc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      sel_ff      <= sel_in;
      cur_ff      <= cur_in;
      probe_ff    <= probe_in;
      root_a_ff   <= root_a_in;
      root_b_ff   <= root_b_in;
      size_a_ff   <= size_a_in;
      size_b_ff   <= size_b_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      a_big_ff    <= a_big_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data        = rsp_data_ff;
   assign status.clearing = (state_ff == S_CLEAR);
   assign status.busy     = (state_ff != S_IDLE);

endmodule

### src/timestamped_union_find_unit.sv
// top level of the timestamped union-find unit: sequencer plus node memory
// depends on tuf_pkg, tuf_node_ram, tuf_seq and assert_macros.svh
//
//   channel  direction  payload        transfer when
//   req_     in         tuf_req_type   req_valid && !req_stall
//   rsp_     out        tuf_rsp_type   rsp_valid && !rsp_stall
//
// after reset a clearing pass initializes all 4096 nodes in turn; req_stall is high meanwhile
// merge: walk both nodes to their roots, link them and write the size unless the roots match; hops at most 12
// query: binary search over merge times, walking both nodes per probe; probes at most ceil(log2(merge count + 2))
// the single read port of the node memory bounds each walk: one link is followed per cycle
// one item at a time; a finished result sits in the output register while the next item runs
`timescale 1ns / 1ps
`include "assert_macros.svh"

module timestamped_union_find_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tuf_pkg::tuf_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tuf_pkg::tuf_rsp_type rsp_data
);

   tuf_pkg::tuf_ram_req_type ram_req;
   tuf_pkg::tuf_entry_type   rd_data;
   tuf_pkg::tuf_status_type  status;

   tuf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .ram_req   (ram_req),
      .rd_data   (rd_data),
      .status    (status)
   );

   tuf_node_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   `TUF_ASSERT_SAME(a_clear_stalls, clock, reset, status.clearing, req_stall)
   `TUF_ASSERT_SAME(a_clear_no_rsp, clock, reset, status.clearing, !rsp_valid)
   `TUF_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && !req_stall, status.busy)
   `TUF_ASSERT_SAME(a_no_write_on_walk, clock, reset, ram_req.rd_en, !ram_req.wr_en)

endmodule
